FILE: hdl/mtg_pkg.sv
`default_nettype none

package mtg_pkg;

   localparam int WORD_BITS        = 64;
   localparam int TABLE_WORDS_DEF  = 312;

   localparam logic OP_RESEED = 1'b0;
   localparam logic OP_DRAW   = 1'b1;

   localparam logic [63:0] SEED_MULT    = 64'h5851_F42D_4C95_7F2D;
   localparam logic [63:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
   localparam logic [63:0] UPPER_BITS   = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] LOWER_BITS   = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] TEMPER_D     = 64'h5555_5555_5555_5555;
   localparam logic [63:0] TEMPER_B     = 64'h71D6_7FFF_EDA6_0000;
   localparam logic [63:0] TEMPER_C     = 64'hFFF7_EEE0_0000_0000;

   typedef logic [WORD_BITS-1:0] word_type;

   // seeder to top: a new table word is pushed into the chain, seeding in progress
   typedef struct packed {
      logic push;
      logic busy;
   } mtg_seed_status_type;

   function automatic word_type mtg_twist(input word_type cur, input word_type nxt,
                                          input word_type far);
      word_type x;
      x = (cur & UPPER_BITS) | (nxt & LOWER_BITS);
      return far ^ (x >> 1) ^ (x[0] ? TWIST_MATRIX : '0);
   endfunction

   function automatic word_type mtg_temper(input word_type x);
      word_type y;
      y = x ^ ((x >> 29) & TEMPER_D);
      y = y ^ ((y << 17) & TEMPER_B);
      y = y ^ ((y << 37) & TEMPER_C);
      return y ^ (y >> 43);
   endfunction

endpackage

`default_nettype wire

FILE: hdl/mtg_if.sv
`default_nettype none

interface mtg_req_if import mtg_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     opcode;
   word_type seed_value;

   modport source (output valid, output opcode, output seed_value, input ready);
   modport sink (input valid, input opcode, input seed_value, output ready);
endinterface

interface mtg_rsp_if import mtg_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type random_word;

   modport source (output valid, output random_word, input ready);
   modport sink (input valid, input random_word, output ready);
endinterface

`default_nettype wire

FILE: hdl/mtg_cell.sv
`default_nettype none

// one table word; takes the word on shift_in on every shift
module mtg_cell import mtg_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     shift_en,
   input  wire word_type shift_in,
   output word_type      value
);

   word_type value_ff;
   word_type value_in;

   always_comb begin
      value_in = value_ff;
      if (shift_en) begin
         value_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

`default_nettype wire

FILE: hdl/mtg_seed.sv
`default_nettype none

// seed recurrence: w(i) = mult * (w ^ (w >> 62)) + i, one word per S_MUL, S_SUM pass
module mtg_seed import mtg_pkg::*; #(
   parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire word_type       seed,
   output mtg_seed_status_type status,
   output word_type            word
);

   localparam int IDX_BITS = $clog2(TABLE_WORDS);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_WORDS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_SUM
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   word_type            w_ff;
   word_type            w_in;
   logic [IDX_BITS-1:0] idx_ff;
   logic [IDX_BITS-1:0] idx_in;
   logic [63:0]         p0_ff;
   logic [31:0]         c1_ff;
   logic [31:0]         c2_ff;

   word_type    x;
   logic [63:0] p0;
   logic [31:0] c1;
   logic [31:0] c2;
   logic [31:0] cross_sum;
   word_type    sum;

   assign x         = w_ff ^ (w_ff >> 62);
   assign p0        = {32'b0, x[31:0]} * {32'b0, SEED_MULT[31:0]};
   assign c1        = x[63:32] * SEED_MULT[31:0];
   assign c2        = x[31:0] * SEED_MULT[63:32];
   assign cross_sum = c1_ff + c2_ff;
   assign sum       = p0_ff + {cross_sum, 32'b0} + WORD_BITS'(idx_ff);

   always_comb begin
      state_in    = state_ff;
      w_in        = w_ff;
      idx_in      = idx_ff;
      status.push = 1'b0;
      status.busy = (state_ff != S_IDLE);
      word        = sum;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               status.push = 1'b1;
               word        = seed;
               w_in        = seed;
               idx_in      = IDX_BITS'(1);
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            status.push = 1'b1;
            w_in        = sum;
            if (idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + IDX_BITS'(1);
               state_in = S_MUL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      w_ff   <= w_in;
      idx_ff <= idx_in;
      p0_ff  <= p0;
      c1_ff  <= c1;
      c2_ff  <= c2;
   end

endmodule

`default_nettype wire

FILE: hdl/mersenne_twister_64_generator.sv
// 64-bit mersenne twister (mt19937-64) with one twisted word per draw
// req channel: opcode 0 reseeds the table from seed_value and gives no item back,
//   opcode 1 draws the next tempered word, returned as one item on rsp
// the table is a ring of 312 word cells; the current word always sits in cell 0,
//   a draw twists cells 0, 1 and 156 and shifts the new word in at the far end
// draws: one item per cycle unless rsp stalls; the result shows on rsp in the cycle after acceptance
// reseed: the seed recurrence pushes one word per S_MUL, S_SUM pass through a
//   split 64-bit multiply (three 32x32 products, then the adds), so req.ready stays
//   low from the acceptance of a reseed item until the last table word is pushed
// reset: all cells clear to zero, so draws before any reseed return zero
// rsp stall: the result register holds its item and req.ready drops until
//   the item is taken; a result being taken frees room for the next draw
// a pending result is still delivered while a reseed runs
`default_nettype none

module mersenne_twister_64_generator import mtg_pkg::*; #(
   parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   mtg_req_if.sink   req_port,
   mtg_rsp_if.source rsp_port
);

   // twist partner sits halfway around the ring
   localparam int SHIFT_AHEAD = TABLE_WORDS / 2;

   mtg_seed_status_type seed_status;
   word_type            seed_word;
   word_type            cell_value [TABLE_WORDS];
   word_type            feed;
   word_type            twisted;
   logic                shift_en;
   logic                req_fire;
   logic                draw_fire;
   logic                seed_start;
   logic                rsp_room;

   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   word_type random_word_ff;
   word_type random_word_in;

   // handshake: room when the result register is empty or being emptied
   assign rsp_room       = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = !seed_status.busy && rsp_room;
   assign req_fire       = req_port.valid && req_port.ready;
   assign draw_fire      = req_fire && (req_port.opcode == OP_DRAW);
   assign seed_start     = req_fire && (req_port.opcode == OP_RESEED);

   mtg_seed #(
      .TABLE_WORDS(TABLE_WORDS)
   ) u_seed (
      .clock (clock),
      .reset (reset),
      .start (seed_start),
      .seed  (req_port.seed_value),
      .status(seed_status),
      .word  (seed_word)
   );

   // twist of the current word with its successor and the halfway word
   assign twisted  = mtg_twist(cell_value[0], cell_value[1], cell_value[SHIFT_AHEAD]);
   assign feed     = seed_status.push ? seed_word : twisted;
   assign shift_en = seed_status.push || draw_fire;

   // ring of cells, each but the last taking its upper neighbor's word on a shift, the last taking the feed
   for (genvar g = 0; g < TABLE_WORDS; g++) begin : g_cell
      if (g == TABLE_WORDS - 1) begin : g_last
         mtg_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift_en(shift_en),
            .shift_in(feed),
            .value   (cell_value[g])
         );
      end else begin : g_mid
         mtg_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift_en(shift_en),
            .shift_in(cell_value[g+1]),
            .value   (cell_value[g])
         );
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      random_word_in = random_word_ff;
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (draw_fire) begin
         rsp_valid_in   = 1'b1;
         random_word_in = mtg_temper(twisted);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      random_word_ff <= random_word_in;
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.random_word = random_word_ff;

   // a reseed item always starts the seeder
   a_reseed_starts: assert property (@(posedge clock) disable iff (reset)
      seed_start |=> seed_status.busy)
      else $error("reseed accepted but seeder idle");

   // no draw is taken while the table is being filled
   a_no_draw_in_seed: assert property (@(posedge clock) disable iff (reset)
      seed_status.busy |-> !draw_fire)
      else $error("draw accepted during reseed");

   // seeder and twist never shift the ring in the same cycle
   a_single_feed: assert property (@(posedge clock) disable iff (reset)
      !(seed_status.push && draw_fire))
      else $error("seed push collides with draw");

   // a new result only follows a draw
   a_result_from_draw: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(draw_fire))
      else $error("result without a draw");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none

import mtg_pkg::*;

// tracks the twister state on the stimulus side and holds the words still owed by the block
class mt64_word_tracker;
   word_type    cells[TABLE_WORDS_DEF];
   int unsigned cursor;
   word_type    owed_words[$];
   int unsigned reseeds;
   int unsigned draws;
   int unsigned checked;
   int unsigned wraps;
   int unsigned failures;

   function new();
      foreach (cells[i]) cells[i] = '0;
      cursor   = 0;
      reseeds  = 0;
      draws    = 0;
      checked  = 0;
      wraps    = 0;
      failures = 0;
   endfunction

   // advance the state by one accepted request, queue the word a draw must return
   function void note_request(logic op, word_type seed);
      word_type    w;
      word_type    joined;
      word_type    fresh;
      word_type    y;
      int unsigned nxt;
      int unsigned far;
      if (op == OP_RESEED) begin
         w        = seed;
         cells[0] = w;
         for (int i = 1; i < TABLE_WORDS_DEF; i++) begin
            w        = SEED_MULT * (w ^ (w >> 62)) + 64'(i);
            cells[i] = w;
         end
         cursor = 0;
         reseeds++;
      end else begin
         nxt = (cursor + 1) % TABLE_WORDS_DEF;
         far = (cursor + 156) % TABLE_WORDS_DEF;
         joined = (cells[cursor] & UPPER_BITS) | (cells[nxt] & LOWER_BITS);
         fresh  = cells[far] ^ (joined >> 1);
         if (joined[0]) fresh = fresh ^ TWIST_MATRIX;
         cells[cursor] = fresh;
         if (nxt == 0) wraps++;
         cursor = nxt;
         y = fresh ^ ((fresh >> 29) & TEMPER_D);
         y = y ^ ((y << 17) & TEMPER_B);
         y = y ^ ((y << 37) & TEMPER_C);
         owed_words.push_back(y ^ (y >> 43));
         draws++;
      end
   endfunction

   function void match_word(word_type actual);
      word_type want;
      if (owed_words.size() == 0) begin
         $error("random_word: item with no draw waiting, actual %h", actual);
         failures++;
         return;
      end
      want = owed_words.pop_front();
      checked++;
      if (actual !== want) begin
         $error("random_word: expected %h, actual %h", want, actual);
         failures++;
      end
   endfunction

   function int outstanding();
      return owed_words.size();
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1200;

   logic clock = 1'b0;
   logic reset;

   // when set, neither side inserts gaps or stalls
   bit steady_phase;

   int unsigned item_count;

   mt64_word_tracker tracker;

   mtg_req_if req_bus ();
   mtg_rsp_if rsp_bus ();

   mersenne_twister_64_generator u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus.sink),
      .rsp_port (rsp_bus.source)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // per-item wait for either side, zero during steady stretches
   function automatic int pick_wait();
      if (steady_phase) return 0;
      return $urandom_range(0, 6);
   endfunction

   function automatic word_type random_word64();
      return {$urandom(), $urandom()};
   endfunction

   // present one request, hold it until accepted, then let the tracker see it
   // valid stays high straight into the next item when no gap is drawn
   task automatic send_item(logic op, word_type seed);
      int gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.seed_value <= seed;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_request(op, seed);
      item_count++;
   endtask

   // a draw carries a random seed field too, the block has to ignore it
   task automatic send_draws(int count);
      repeat (count) send_item(OP_DRAW, random_word64());
   endtask

   // sender holds off until every owed word has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // result side: random stall before each item, ready held high until it is taken
   initial begin
      int stall;
      forever begin
         stall = pick_wait();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // every accepted result goes against the oldest owed word
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         tracker.match_word(rsp_bus.random_word);
      end
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int       run_len;
      int       pick;
      word_type seed;
      tracker            = new();
      item_count         = 0;
      steady_phase       = 1'b0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OP_DRAW;
      req_bus.seed_value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // draws straight out of reset twist an all-zero table, so zeros come back
      send_draws(3);
      // zero seed
      send_item(OP_RESEED, 64'h0);
      send_draws(3);
      // sender waits for every owed word before going on
      drain_results();
      // all-ones seed, the top bits feed the w >> 62 term
      send_item(OP_RESEED, '1);
      send_draws(3);
      // the usual default seed of the published generator
      send_item(OP_RESEED, 64'd5489);
      send_draws(4);
      // only the top bit set
      send_item(OP_RESEED, 64'h8000_0000_0000_0000);
      send_draws(2);
      // two reseeds back to back, only the second one counts
      send_item(OP_RESEED, 64'h1);
      send_item(OP_RESEED, random_word64());
      send_draws(2);

      // --- random part ---
      // mostly a reseed followed by a run of draws; some runs go past a full
      // table so the position and the far index both wrap; the rest is noise
      while (item_count < ITEM_TARGET) begin
         steady_phase = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 85) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) seed = '0;
            else if (pick == 1) seed = '1;
            else if (pick == 2) seed = 64'($urandom_range(0, 15));
            else seed = random_word64();
            send_item(OP_RESEED, seed);
            if ($urandom_range(0, 4) == 0) run_len = $urandom_range(313, 640);
            else run_len = $urandom_range(1, 60);
            // keep the total close to the target
            if (int'(item_count) + run_len > ITEM_TARGET + 20)
               run_len = ITEM_TARGET + 20 - int'(item_count);
            send_draws(run_len);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 3) == 0) send_item(OP_RESEED, random_word64());
               else send_item(OP_DRAW, random_word64());
            end
         end
      end
      steady_phase  = 1'b0;
      req_bus.valid <= 1'b0;

      // wait for the last owed word, then watch a while for stray items
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("run covered %0d reseeds and %0d draws, %0d words checked",
               tracker.reseeds, tracker.draws, tracker.checked);
      $display("the draw position wrapped around the table %0d times", tracker.wraps);
      if (tracker.failures == 0 && tracker.outstanding() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
hdl/mtg_pkg.sv
hdl/mtg_if.sv
hdl/mtg_cell.sv
hdl/mtg_seed.sv
hdl/mersenne_twister_64_generator.sv
bench/testbench.sv
